// File: design/max_heap_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// max_heap_priority_queue_macros
// Assertion macros shared by the priority queue checker.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// property holds at every clock edge outside reset
`define MHPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mhpq assertion failed");

// consequent holds in the cycle after the antecedent
`define MHPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mhpq sequencing assertion failed");

`endif

// File: design/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and constants of the max priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int KeyW            = 32;
  localparam int StatusW         = 2;
  localparam int FillW           = 5;
  localparam int DefaultCapacity = 31;

  // command codes on the input port
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // operation broadcast to the cell row
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } cell_op_e;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                   vld;
    logic                   ge;   // holds a key >= the broadcast key
    logic signed [KeyW-1:0] key;
  } link_t;

endpackage

`default_nettype wire

// File: design/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted key row; shifts toward its neighbors on push/pop.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mhpq_pkg::cell_op_e               op_i,
  input  wire logic signed [mhpq_pkg::KeyW-1:0] bkey_i,
  input  wire mhpq_pkg::link_t                  left_i,
  input  wire mhpq_pkg::link_t                  right_i,
  output mhpq_pkg::link_t                       link_o
);
  import mhpq_pkg::*;

  logic                   vld_q, vld_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic                   ge;

  // this slot keeps its key on a push
  assign ge     = vld_q && (key_q >= bkey_i);
  assign link_o = '{vld: vld_q, ge: ge, key: key_q};

  // next slot contents
  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    unique case (op_i)
      CELL_HOLD: begin
      end
      CELL_PUSH: begin
        if (!ge) begin
          if (left_i.ge) begin
            key_d = bkey_i;
            vld_d = 1'b1;
          end else begin
            key_d = left_i.key;
            vld_d = left_i.vld;
          end
        end
      end
      CELL_POP: begin
        key_d = right_i.key;
        vld_d = right_i.vld;
      end
      default: begin
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // key payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

// File: design/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Max priority queue of signed keys held sorted in a row of cells.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// command   in         start_i / busy_o   cmd_i, key_i
// result    out        strobe_o           value_o, status_o, fill_o
//
// The cell row updates at the accepting edge, and the result shows in the
// next cycle with strobe_o for one cycle. busy_o is high during that result
// cycle, so no new command is accepted while a result is shown; capacity
// does not change the timing.
// Reset empties the row by clearing the cell occupancy flags.
// The receiver cannot stall the result.
`default_nettype none

module max_heap_priority_queue #(
  parameter int Capacity = mhpq_pkg::DefaultCapacity
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              cmd_i,
  input  wire logic signed [mhpq_pkg::KeyW-1:0]  key_i,
  output logic                                   strobe_o,
  output logic signed [mhpq_pkg::KeyW-1:0]       value_o,
  output logic [mhpq_pkg::StatusW-1:0]           status_o,
  output logic [mhpq_pkg::FillW-1:0]             fill_o
);
  import mhpq_pkg::*;

  localparam int CntW = $clog2(Capacity + 1);

  logic                   accept;
  logic                   full, empty;
  cell_op_e               op;
  status_e                status_d;
  logic signed [KeyW-1:0] value_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW+FillW-1:0]  count_ext;

  logic                   strobe_q;
  logic signed [KeyW-1:0] value_q;
  status_e                status_q;
  logic [CntW-1:0]        fill_q;

  link_t links [Capacity];

  assign accept = start_i && !busy_o;
  assign full   = (count_q == CntW'(Capacity));
  assign empty  = (count_q == '0);

  // command decode
  always_comb begin
    op       = CELL_HOLD;
    status_d = ST_OK;
    value_d  = '0;
    count_d  = count_q;
    if (accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            op      = CELL_PUSH;
            count_d = count_q + CntW'(1);
          end
        end
        CMD_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            op      = CELL_POP;
            value_d = links[0].key;
            count_d = count_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // cell row, largest key in slot zero
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    link_t left, right;
    if (i == 0) begin : g_first
      assign left = '{vld: 1'b1, ge: 1'b1, key: '0};
    end else begin : g_mid_l
      assign left = links[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right = '{vld: 1'b0, ge: 1'b0, key: '0};
    end else begin : g_mid_r
      assign right = links[i+1];
    end
    mhpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .bkey_i  (key_i),
      .left_i  (left),
      .right_i (right),
      .link_o  (links[i])
    );
  end

  // fill count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      strobe_q <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q  <= value_d;
      status_q <= status_d;
      fill_q   <= count_d;
    end
  end

  // fill reported modulo the field width
  assign count_ext = (CntW+FillW)'(fill_q);

  assign busy_o   = strobe_q;
  assign strobe_o = strobe_q;
  assign value_o  = value_q;
  assign status_o = status_q;
  assign fill_o   = count_ext[FillW-1:0];

endmodule

`default_nettype wire

// File: design/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks of the max priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_heap_priority_queue_macros.svh"

module mhpq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start_i,
  input wire logic                              busy_o,
  input wire logic                              cmd_i,
  input wire logic                              strobe_o,
  input wire logic signed [mhpq_pkg::KeyW-1:0]  value_o,
  input wire logic [mhpq_pkg::StatusW-1:0]      status_o,
  input wire logic [mhpq_pkg::FillW-1:0]        fill_o
);
  import mhpq_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // every accepted transaction gives a result in the next cycle
  `MHPQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, accept, strobe_o)
  // no result without an accepted transaction
  `MHPQ_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !accept, !strobe_o)
  // a push never returns a key
  `MHPQ_ASSERT_NEXT(a_push_zero, clk_i, rst_ni, accept && (cmd_i == CMD_PUSH),
                    (value_o == '0) && (status_o != ST_EMPTY))
  // an empty pop leaves the queue empty
  `MHPQ_ASSERT(a_empty_pop, clk_i, rst_ni,
               (strobe_o && (status_o == ST_EMPTY)) |-> ((fill_o == '0) && (value_o == '0)))

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

`default_nettype wire
